>>> hw/rtl/pli_pkg.sv
`default_nettype none

package pli_pkg;

   localparam int DEPTH = 16;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int POS_W = 5;
   localparam int VAL_W = 32;
   localparam int LEN_W = 5;
   localparam int ST_W  = 2;
   // compare width wide enough for both count and position, plus one
   localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_DELETE = 1'b1;

   localparam logic [ST_W-1:0] STATUS_OK     = 2'd0;
   localparam logic [ST_W-1:0] STATUS_BADPOS = 2'd1;
   localparam logic [ST_W-1:0] STATUS_FULL   = 2'd2;

   typedef struct packed {
      logic                     kind;
      logic [POS_W-1:0]         position;
      logic signed [VAL_W-1:0]  item_value;
   } req_type;

   typedef struct packed {
      logic [ST_W-1:0]          status;
      logic signed [VAL_W-1:0]  removed_value;
      logic [LEN_W-1:0]         list_length;
   } rsp_type;

   typedef struct packed {
      logic              wr_en;
      logic [IDX_W-1:0]  wr_addr;
      logic [VAL_W-1:0]  wr_data;
      logic [IDX_W-1:0]  rd_addr;
   } ram_ctrl_type;

   typedef struct packed {
      logic              dec;
      logic [CNT_W-1:0]  a;
      logic [CNT_W-1:0]  b;
   } step_ctrl_type;

   typedef struct packed {
      logic [CNT_W-1:0]  res;
      logic              res_lt_b;
      logic              b_lt_a;
   } step_res_type;

endpackage

`default_nettype wire

>>> hw/rtl/pli_ram.sv
`default_nettype none

module pli_ram (
   input  wire                            clock,
   input  pli_pkg::ram_ctrl_type          ctrl,
   output logic [pli_pkg::VAL_W-1:0]      rd_data
);
   import pli_pkg::*;

   logic [VAL_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem[ctrl.wr_addr] <= ctrl.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[ctrl.rd_addr];
   end

endmodule

`default_nettype wire

>>> hw/rtl/pli_step.sv
`default_nettype none

// Shared index unit: increment or decrement plus two compares.
module pli_step (
   input  pli_pkg::step_ctrl_type  ctrl,
   output pli_pkg::step_res_type   result
);
   import pli_pkg::*;

   logic [CNT_W-1:0] sum;

   always_comb begin
      if (ctrl.dec) begin
         sum = ctrl.a - CNT_W'(1);
      end else begin
         sum = ctrl.a + CNT_W'(1);
      end
      result.res      = sum;
      result.res_lt_b = (sum < ctrl.b);
      result.b_lt_a   = (ctrl.b < ctrl.a);
   end

endmodule

`default_nettype wire

>>> hw/rtl/positional_list_insert_delete.sv
// Positional list of up to DEPTH signed 32-bit values, 1-based positions.
// Request channel (req_valid/req_stall/req_data): kind 0 inserts item_value
// at position, moving later entries up; kind 1 deletes the entry at
// position, moving later entries down. Each transfer gives one response
// (rsp_valid/rsp_stall/rsp_data): status, removed value and new length.
// Entries move one place at a time, each read then written, through a list
// memory with one write port and one registered read port, driven by one
// shared index unit. An item moves m entries, m being at most the length;
// a rejected item moves none and goes straight to its response.
// req_stall is high whilst an item is being worked on. The response sits in
// an output register; a new request is taken while it waits, but the next
// result is held until the previous one has been transferred.
// Reset empties the list and drops any pending response; memory contents
// are left as they are and are never read before being written.
`default_nettype none

module positional_list_insert_delete (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_stall,
   input  pli_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output pli_pkg::rsp_type  rsp_data
);
   import pli_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_INS_RD, S_INS_WR, S_INS_PUT, S_DEL_RD, S_DEL_CAP,
      S_DEL_SHRD, S_DEL_SHWR, S_DEL_FIN, S_RESP
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  wa_ff, wa_in;
   logic [CNT_W-1:0]  pm1_ff, pm1_in;
   logic [VAL_W-1:0]  val_ff, val_in;
   logic [ST_W-1:0]   status_ff, status_in;
   logic [VAL_W-1:0]  removed_ff, removed_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   ram_ctrl_type      ram_ctrl;
   logic [VAL_W-1:0]  rd_data;
   step_ctrl_type     step_ctrl;
   step_res_type      step_res;

   logic [CMP_W-1:0]  pos_x, cnt_x;
   logic              pos_zero, ins_bad, ins_full, del_bad, ins_shift;
   logic              rsp_load;

   pli_ram u_ram (
      .clock   (clock),
      .ctrl    (ram_ctrl),
      .rd_data (rd_data)
   );

   pli_step u_step (
      .ctrl   (step_ctrl),
      .result (step_res)
   );

   always_comb begin
      pos_x     = CMP_W'(req_data.position);
      cnt_x     = CMP_W'(count_ff);
      pos_zero  = (req_data.position == '0);
      ins_bad   = pos_zero || (pos_x > (cnt_x + CMP_W'(1)));
      ins_full  = (cnt_x == CMP_W'(DEPTH));
      del_bad   = pos_zero || (pos_x > cnt_x);
      ins_shift = (pos_x <= cnt_x);
   end

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      wa_in      = wa_ff;
      pm1_in     = pm1_ff;
      val_in     = val_ff;
      status_in  = status_ff;
      removed_in = removed_ff;
      rsp_load   = 1'b0;

      ram_ctrl.wr_en   = 1'b0;
      ram_ctrl.wr_addr = wa_ff[IDX_W-1:0];
      ram_ctrl.wr_data = rd_data;
      ram_ctrl.rd_addr = idx_ff[IDX_W-1:0];

      step_ctrl.dec = 1'b0;
      step_ctrl.a   = idx_ff;
      step_ctrl.b   = count_ff;

      case (state_ff)
         S_IDLE: begin
            step_ctrl.dec = 1'b1;
            step_ctrl.a   = count_ff;
            if (req_valid) begin
               val_in     = req_data.item_value;
               pm1_in     = CNT_W'(pos_x - CMP_W'(1));
               removed_in = '0;
               if (req_data.kind == KIND_INSERT) begin
                  if (ins_bad) begin
                     status_in = STATUS_BADPOS;
                     state_in  = S_RESP;
                  end else if (ins_full) begin
                     status_in = STATUS_FULL;
                     state_in  = S_RESP;
                  end else begin
                     status_in = STATUS_OK;
                     idx_in    = step_res.res;
                     wa_in     = count_ff;
                     state_in  = ins_shift ? S_INS_RD : S_INS_PUT;
                  end
               end else begin
                  if (del_bad) begin
                     status_in = STATUS_BADPOS;
                     state_in  = S_RESP;
                  end else begin
                     status_in = STATUS_OK;
                     idx_in    = CNT_W'(pos_x - CMP_W'(1));
                     state_in  = S_DEL_RD;
                  end
               end
            end
         end
         S_INS_RD: begin
            state_in = S_INS_WR;
         end
         S_INS_WR: begin
            ram_ctrl.wr_en = 1'b1;
            step_ctrl.dec  = 1'b1;
            step_ctrl.b    = pm1_ff;
            wa_in          = idx_ff;
            idx_in         = step_res.res;
            state_in       = step_res.b_lt_a ? S_INS_RD : S_INS_PUT;
         end
         S_INS_PUT: begin
            ram_ctrl.wr_en   = 1'b1;
            ram_ctrl.wr_addr = pm1_ff[IDX_W-1:0];
            ram_ctrl.wr_data = val_ff;
            step_ctrl.a      = count_ff;
            count_in         = step_res.res;
            state_in         = S_RESP;
         end
         S_DEL_RD: begin
            state_in = S_DEL_CAP;
         end
         S_DEL_CAP: begin
            removed_in = rd_data;
            wa_in      = idx_ff;
            idx_in     = step_res.res;
            state_in   = step_res.res_lt_b ? S_DEL_SHRD : S_DEL_FIN;
         end
         S_DEL_SHRD: begin
            state_in = S_DEL_SHWR;
         end
         S_DEL_SHWR: begin
            ram_ctrl.wr_en = 1'b1;
            wa_in          = idx_ff;
            idx_in         = step_res.res;
            state_in       = step_res.res_lt_b ? S_DEL_SHRD : S_DEL_FIN;
         end
         S_DEL_FIN: begin
            step_ctrl.dec = 1'b1;
            step_ctrl.a   = count_ff;
            count_in      = step_res.res;
            state_in      = S_RESP;
         end
         S_RESP: begin
            // previous response must have been transferred first
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_in.status        = status_ff;
      rsp_in.removed_value = removed_ff;
      rsp_in.list_length   = LEN_W'(count_ff);
      rsp_valid_in         = rsp_load ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff     <= idx_in;
      wa_ff      <= wa_in;
      pm1_ff     <= pm1_in;
      val_ff     <= val_in;
      status_ff  <= status_in;
      removed_ff <= removed_in;
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(count_ff) <= CMP_W'(DEPTH))
      else $error("list length beyond capacity");

   a_ins_move_adjacent: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INS_WR) |-> (wa_ff == idx_ff + CNT_W'(1)))
      else $error("insert move not between adjacent entries");

   a_del_move_adjacent: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DEL_SHWR) |-> (idx_ff == wa_ff + CNT_W'(1)))
      else $error("delete move not between adjacent entries");

   a_count_change: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |->
         ($past(state_ff) == S_INS_PUT || $past(state_ff) == S_DEL_FIN))
      else $error("length changed outside a completing item");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_RESP))
      else $error("response raised without a finished item");

endmodule

`default_nettype wire
